>>> hw/rtl/hsl_hue_rotation_palette_defines.svh
// ---------------------------------------------------------------------------
// HSL palette assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef HSL_HUE_ROTATION_PALETTE_DEFINES_SVH
`define HSL_HUE_ROTATION_PALETTE_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define HHR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hhr assertion failed");
// Check a property on every clock edge, reset included.
`define HHR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("hhr assertion failed");
`else
`define HHR_ASSERT(lbl, prop)
`define HHR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> hw/rtl/hhr_pkg.sv
// ---------------------------------------------------------------------------
// HSL palette package
// Shared types, fixed-point constants and small helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package hhr_pkg;

  localparam int unsigned HueW = 17;
  localparam int unsigned FracW = 17;

  localparam logic [HueW-1:0] HueTurn = 17'd92160;
  localparam logic [HueW-1:0] HueThird = 17'd30720;
  localparam logic [HueW-1:0] HueSixth = 17'd15360;
  localparam logic [HueW-1:0] HueHalf = 17'd46080;
  localparam logic [HueW-1:0] HueTwoThirds = 17'd61440;
  localparam logic [FracW-1:0] Unit = 17'd65536;

  // Divider lane geometry: 18 quotient bits, 6 per cycle
  localparam int unsigned DivRemW = 10;
  localparam int unsigned DivQuoW = 18;
  localparam int unsigned DivStepsPerCycle = 6;

  // Reciprocal of 15 for a 21-bit dividend, exact with a 25-bit shift
  localparam logic [21:0] RecipFifteen = 22'd2236963;
  localparam int unsigned RecipShift = 25;

  typedef enum logic [1:0] {
    SchemeSingle = 2'd0,
    SchemeComplement = 2'd1,
    SchemeTriadic = 2'd2,
    SchemeAnalogous = 2'd3
  } scheme_e;

  typedef enum logic [1:0] {
    RegionRise,
    RegionHigh,
    RegionFall,
    RegionLow
  } region_e;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [FracW-1:0] sat;
    logic [FracW-1:0] lum;
  } hsl_t;

  typedef struct packed {
    logic [DivRemW-1:0] rem;
    logic [DivQuoW-1:0] quo;
  } div_lane_t;

  function automatic div_lane_t div_steps(div_lane_t cur, logic [DivRemW-1:0] dvs);
    div_lane_t nxt;
    logic [DivRemW:0] trial;
    nxt = cur;
    for (int i = 0; i < DivStepsPerCycle; i++) begin
      trial = {nxt.rem, nxt.quo[DivQuoW-1]};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        nxt.quo = {nxt.quo[DivQuoW-2:0], 1'b1};
      end else begin
        nxt.quo = {nxt.quo[DivQuoW-2:0], 1'b0};
      end
      nxt.rem = trial[DivRemW-1:0];
    end
    return nxt;
  endfunction

  function automatic logic [1:0] scheme_count(scheme_e mode);
    case (mode)
      SchemeSingle: return 2'd1;
      SchemeComplement: return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  function automatic logic [HueW-1:0] hue_offset(scheme_e mode, logic [1:0] idx);
    logic [HueW-1:0] off;
    off = '0;
    case (mode)
      SchemeComplement: if (idx == 2'd1) off = 17'd46080;
      SchemeTriadic: begin
        if (idx == 2'd1) off = 17'd30720;
        else if (idx == 2'd2) off = 17'd61440;
      end
      SchemeAnalogous: begin
        if (idx == 2'd0) off = 17'd84480;
        else if (idx == 2'd2) off = 17'd7680;
      end
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hhr_front.sv
// ---------------------------------------------------------------------------
// HSL palette front end
// Accept a base color, find max/min, run three radix-64 dividers for L, S, H.
// ---------------------------------------------------------------------------
`default_nettype none

module hhr_front import hhr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] base_red_i,
  input  wire logic [7:0] base_green_i,
  input  wire logic [7:0] base_blue_i,
  output logic            push_o,
  output hsl_t            push_data_o,
  input  wire logic       full_i
);

  logic busy_q, busy_d;
  logic [1:0] cnt_q, cnt_d;
  div_lane_t lane_q [3];
  div_lane_t lane_d [3];
  div_lane_t lane_step [3];
  logic [DivRemW-1:0] dvs_q [3];
  logic [DivRemW-1:0] dvs_d [3];

  logic [7:0] mx, mn, dd;
  logic [8:0] sum;
  logic [7:0] den;
  logic [11:0] num_h;
  logic [26:0] numer [3];
  logic [DivRemW-1:0] dvs_in [3];
  logic grey, finish, accept;
  logic [HueW-1:0] hue_raw;

  always_comb begin
    mx = base_red_i;
    mn = base_red_i;
    if (base_green_i > mx) mx = base_green_i;
    if (base_blue_i > mx) mx = base_blue_i;
    if (base_green_i < mn) mn = base_green_i;
    if (base_blue_i < mn) mn = base_blue_i;
    dd = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    grey = (dd == 8'd0);
    den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    // Hue sector numerator, red wins ties, then green
    if (mx == base_red_i) begin
      if (base_green_i >= base_blue_i) num_h = 12'(base_green_i - base_blue_i);
      else num_h = 12'(12'd6 * {4'd0, dd}) - 12'({4'd0, base_blue_i} - {4'd0, base_green_i});
    end else if (mx == base_green_i) begin
      num_h = 12'({3'd0, dd, 1'b0} + {4'd0, base_blue_i} - {4'd0, base_red_i});
    end else begin
      num_h = 12'({2'd0, dd, 2'b0} + {4'd0, base_red_i} - {4'd0, base_green_i});
    end
    // Round half up: q = (2n + d) / (2d)
    numer[0] = {1'b0, sum, 17'd0} + 27'd510;
    dvs_in[0] = 10'd1020;
    numer[1] = grey ? 27'd0 : {2'd0, dd, 17'd0} + {19'd0, den};
    dvs_in[1] = grey ? 10'd2 : {1'b0, den, 1'b0};
    numer[2] = grey ? 27'd0 : 27'(num_h * 27'd30720) + {19'd0, dd};
    dvs_in[2] = grey ? 10'd2 : {1'b0, dd, 1'b0};
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign lane_step[g] = div_steps(lane_q[g], dvs_q[g]);
  end

  assign finish = busy_q && (cnt_q == 2'd2) && !full_i;
  assign in_stall_o = busy_q && !finish;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    for (int i = 0; i < 3; i++) begin
      lane_d[i] = lane_q[i];
      dvs_d[i] = dvs_q[i];
    end
    if (busy_q && cnt_q != 2'd2) begin
      cnt_d = cnt_q + 2'd1;
      for (int i = 0; i < 3; i++) lane_d[i] = lane_step[i];
    end
    if (finish) busy_d = 1'b0;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d = 2'd0;
      for (int i = 0; i < 3; i++) begin
        lane_d[i].rem = {1'b0, numer[i][26:18]};
        lane_d[i].quo = numer[i][17:0];
        dvs_d[i] = dvs_in[i];
      end
    end
  end

  // Final quotients come straight off the last step
  assign hue_raw = lane_step[2].quo[HueW-1:0];
  assign push_o = finish;
  assign push_data_o.lum = lane_step[0].quo[FracW-1:0];
  assign push_data_o.sat = lane_step[1].quo[FracW-1:0];
  assign push_data_o.hue = (hue_raw >= HueTurn) ? hue_raw - HueTurn : hue_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      lane_q[i] <= lane_d[i];
      dvs_q[i] <= dvs_d[i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hhr_fifo.sv
// ---------------------------------------------------------------------------
// HSL palette request queue
// Small register FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module hhr_fifo import hhr_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  hsl_t      push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output hsl_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsl_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/hhr_back.sv
// ---------------------------------------------------------------------------
// HSL palette back end
// Derive p/q per request, then issue one rotated color per cycle to RGB unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module hhr_back import hhr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  scheme_e         scheme_i,
  input  wire logic       fifo_valid_i,
  input  hsl_t            fifo_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o,
  output logic [1:0]      color_index_o,
  output logic            last_color_o
);

  logic en;
  logic [1:0] count;

  // Product stage
  logic p_valid_q;
  hsl_t p_hsl_q;
  logic [34:0] p_prod_q;
  logic p_take;
  logic [17:0] mul_op;

  // Item stage: holds p/q while colors issue
  logic s_valid_q;
  logic [1:0] s_k_q;
  logic [HueW-1:0] s_hue_q;
  logic [FracW-1:0] s_p_q, s_q_q;
  logic s_last, s_take;
  logic [18:0] q_calc, twol;
  logic [FracW-1:0] q_sat, p_calc;
  logic [18:0] rnd;

  // Color pipeline
  logic c0_valid_q, c1_valid_q, c2_valid_q;
  logic [1:0] c0_idx_q, c1_idx_q, c2_idx_q;
  logic c0_last_q, c1_last_q, c2_last_q;
  region_e c0_reg_q [3];
  region_e c1_reg_q [3];
  region_e c2_reg_q [3];
  logic [13:0] c0_fac_q [3];
  logic [FracW-1:0] c0_p_q, c0_q_q, c0_diff_q;
  logic [FracW-1:0] c1_p_q, c1_q_q, c2_p_q, c2_q_q;
  logic [30:0] c1_prod_q [3];
  logic [42:0] c2_xm_q [3];

  logic [17:0] h_sum;
  logic [HueW-1:0] h_rot;
  logic [HueW-1:0] t_pos [3];
  region_e reg_c [3];
  logic [13:0] fac_c [3];
  logic [20:0] x_c [3];
  logic [7:0] byte_c [3];

  logic out_valid_q;
  logic [7:0] out_byte_q [3];
  logic [1:0] out_idx_q;
  logic out_last_q;

  assign en = !(out_valid_q && out_stall_i);
  assign count = scheme_count(scheme_i);
  assign s_last = (s_k_q == count - 2'd1);
  assign s_take = en && (!s_valid_q || s_last);
  assign p_take = en && (!p_valid_q || s_take);
  assign pop_o = p_take && fifo_valid_i;

  // Choose the q formula operand by lightness half
  assign mul_op = fifo_data_i.lum[15] | fifo_data_i.lum[16] ?
                  {1'b0, fifo_data_i.sat} : 18'(Unit) + {1'b0, fifo_data_i.sat};

  always_comb begin
    rnd = 19'((p_prod_q + 35'd32768) >> 16);
    if (p_hsl_q.lum < 17'd32768) q_calc = rnd;
    else q_calc = {2'd0, p_hsl_q.lum} + {2'd0, p_hsl_q.sat} - rnd;
    q_sat = (q_calc > {2'd0, Unit}) ? Unit : q_calc[FracW-1:0];
    twol = {1'b0, p_hsl_q.lum, 1'b0};
    p_calc = (twol >= {2'd0, q_sat}) ? 17'(twol - {2'd0, q_sat}) : '0;
    // Grey: both ends collapse to lightness
    if (p_hsl_q.sat == '0) begin
      q_sat = p_hsl_q.lum;
      p_calc = p_hsl_q.lum;
    end
  end

  always_comb begin
    h_sum = {1'b0, s_hue_q} + {1'b0, hue_offset(scheme_i, s_k_q)};
    h_rot = (h_sum >= {1'b0, HueTurn}) ? 17'(h_sum - {1'b0, HueTurn}) : h_sum[HueW-1:0];
    t_pos[0] = (h_rot >= HueTurn - HueThird) ? h_rot - (HueTurn - HueThird)
                                              : h_rot + HueThird;
    t_pos[1] = h_rot;
    t_pos[2] = (h_rot >= HueThird) ? h_rot - HueThird : h_rot + (HueTurn - HueThird);
    for (int i = 0; i < 3; i++) begin
      if (t_pos[i] < HueSixth) begin
        reg_c[i] = RegionRise;
        fac_c[i] = t_pos[i][13:0];
      end else if (t_pos[i] < HueHalf) begin
        reg_c[i] = RegionHigh;
        fac_c[i] = '0;
      end else if (t_pos[i] < HueTwoThirds) begin
        reg_c[i] = RegionFall;
        fac_c[i] = 14'(HueTwoThirds - t_pos[i]);
      end else begin
        reg_c[i] = RegionLow;
        fac_c[i] = '0;
      end
    end
  end

  always_comb begin
    logic [17:0] quo;
    logic [17:0] v;
    logic [25:0] scaled;
    for (int i = 0; i < 3; i++) begin
      x_c[i] = 21'(({c1_prod_q[i], 1'b0} + 32'd15360) >> 11);
      quo = 18'(c2_xm_q[i] >> RecipShift);
      case (c2_reg_q[i])
        RegionRise, RegionFall: v = {1'b0, c2_p_q} + quo;
        RegionHigh: v = {1'b0, c2_q_q};
        default: v = {1'b0, c2_p_q};
      endcase
      if (v > {1'b0, Unit}) v = {1'b0, Unit};
      scaled = ({8'd0, v} << 9) - {7'd0, v, 1'b0} + 26'd65536;
      byte_c[i] = scaled[24:17];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      s_k_q <= 2'd0;
      c0_valid_q <= 1'b0;
      c1_valid_q <= 1'b0;
      c2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      if (p_take) p_valid_q <= fifo_valid_i;
      if (s_take) begin
        s_valid_q <= p_valid_q;
        s_k_q <= 2'd0;
      end else begin
        s_k_q <= s_k_q + 2'd1;
      end
      c0_valid_q <= s_valid_q;
      c1_valid_q <= c0_valid_q;
      c2_valid_q <= c1_valid_q;
      out_valid_q <= c2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_hsl_q <= fifo_data_i;
      p_prod_q <= {18'd0, fifo_data_i.lum} * {17'd0, mul_op};
    end
    if (en) begin
      if (s_take && p_valid_q) begin
        s_hue_q <= p_hsl_q.hue;
        s_q_q <= q_sat;
        s_p_q <= p_calc;
      end
      c0_idx_q <= s_k_q;
      c0_last_q <= s_last;
      c0_p_q <= s_p_q;
      c0_q_q <= s_q_q;
      c0_diff_q <= (s_q_q > s_p_q) ? s_q_q - s_p_q : '0;
      c1_idx_q <= c0_idx_q;
      c1_last_q <= c0_last_q;
      c1_p_q <= c0_p_q;
      c1_q_q <= c0_q_q;
      c2_idx_q <= c1_idx_q;
      c2_last_q <= c1_last_q;
      c2_p_q <= c1_p_q;
      c2_q_q <= c1_q_q;
      out_idx_q <= c2_idx_q;
      out_last_q <= c2_last_q;
      for (int i = 0; i < 3; i++) begin
        c0_reg_q[i] <= reg_c[i];
        c0_fac_q[i] <= fac_c[i];
        c1_reg_q[i] <= c0_reg_q[i];
        c1_prod_q[i] <= {14'd0, c0_diff_q} * {17'd0, c0_fac_q[i]};
        c2_reg_q[i] <= c1_reg_q[i];
        c2_xm_q[i] <= {22'd0, x_c[i]} * {21'd0, RecipFifteen};
        out_byte_q[i] <= byte_c[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o = out_byte_q[0];
  assign out_green_o = out_byte_q[1];
  assign out_blue_o = out_byte_q[2];
  assign color_index_o = out_idx_q;
  assign last_color_o = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/hsl_hue_rotation_palette.sv
// ---------------------------------------------------------------------------
// HSL hue rotation palette
// RGB to HSL, scheme-driven hue rotation, HSL back to RGB bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i/in_stall_o carry one base color request
//   (base_red_i, base_green_i, base_blue_i). Output channel:
//   out_valid_o/out_stall_i carry one palette color per request of the
//   output side, with color_index_o and last_color_o marking its place.
//   scheme_mode is to be written through cfg_we_i/cfg_wdata_i only while
//   idle; the block does not enforce this. Throughput: the front end takes
//   a new base color only once its three dividers, 6 quotient bits per cycle
//   each, finish the previous one. The back end issues one color per cycle
//   when not stalled, so single and complement modes leave it partly idle
//   and three-color modes keep the output busy every cycle. Path: dividers,
//   queue, product and item stages for p/q, then 4 color stages.
// Reset: clears all valid state and sets scheme_mode to single; no clearing
//   pass is needed. While the receiver stalls, the color pipeline holds,
//   the queue fills, and then the input stalls.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsl_hue_rotation_palette_defines.svh"

module hsl_hue_rotation_palette import hhr_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] base_red_i,
  input  wire logic [7:0] base_green_i,
  input  wire logic [7:0] base_blue_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o,
  output logic [1:0]      color_index_o,
  output logic            last_color_o
);

  scheme_e scheme_q, scheme_d;
  logic push, full, pop, fifo_valid;
  hsl_t push_data, pop_data;

  // Hold the scheme until the next write
  always_comb begin
    scheme_d = scheme_q;
    if (cfg_we_i) scheme_d = scheme_e'(cfg_wdata_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= SchemeSingle;
    end else begin
      scheme_q <= scheme_d;
    end
  end

  // Front: classify the base color and divide out L, S, H
  hhr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .base_red_i   (base_red_i),
    .base_green_i (base_green_i),
    .base_blue_i  (base_blue_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  // Queue: decouple the divider from output back-pressure
  hhr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (pop_data)
  );

  // Back: rotate hues and convert each color back to RGB
  hhr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scheme_i      (scheme_q),
    .fifo_valid_i  (fifo_valid),
    .fifo_data_i   (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .color_index_o (color_index_o),
    .last_color_o  (last_color_o)
  );

  `HHR_ASSERT(a_no_overflow, !(push && full))
  `HHR_ASSERT(a_no_underflow, !(pop && !fifo_valid))
  `HHR_ASSERT(a_index_two_is_last, (out_valid_o && color_index_o == 2'd2) |-> last_color_o)

endmodule

`default_nettype wire

>>> dv/hhr_palette_checker.sv
// ---------------------------------------------------------------------------
// HSL palette checker
// Watches both channels, predicts palette colors per request and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module hhr_palette_checker import hhr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  logic [7:0] base_red_i,
  input  logic [7:0] base_green_i,
  input  logic [7:0] base_blue_i,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic [7:0] out_red_o,
  input  logic [7:0] out_green_o,
  input  logic [7:0] out_blue_o,
  input  logic [1:0] color_index_o,
  input  logic       last_color_o,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] index;
    logic       last;
  } color_t;

  color_t  palette_q[$];
  scheme_e scheme;

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic logic [7:0] shade_byte(longint unsigned p, longint unsigned q,
                                            longint unsigned t);
    longint unsigned span, v;
    span = (q > p) ? q - p : 0;
    if (t < 15360) v = p + round_div(span * t, 15360);
    else if (t < 46080) v = q;
    else if (t < 61440) v = p + round_div(span * (61440 - t), 15360);
    else v = p;
    if (v > 65536) v = 65536;
    return 8'(round_div(v * 255, 65536));
  endfunction

  function automatic longint unsigned rot_offset(scheme_e m, int k);
    case (m)
      SchemeComplement: return (k == 1) ? 46080 : 0;
      SchemeTriadic:    return (k == 1) ? 30720 : (k == 2) ? 61440 : 0;
      SchemeAnalogous:  return (k == 0) ? 84480 : (k == 2) ? 7680 : 0;
      default:          return 0;
    endcase
  endfunction

  task automatic predict_palette(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    longint unsigned r, g, b, mx, mn, d, lum, sat, hue, num, q, p, h;
    int     count;
    color_t c;
    r = r8; g = g8; b = b8;
    mx = r; mn = r; sat = 0; hue = 0; q = 0; p = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    lum = round_div((mx + mn) * 65536, 510);
    if (mx != mn) begin
      d = mx - mn;
      if (mx + mn <= 255) sat = round_div(d * 65536, mx + mn);
      else sat = round_div(d * 65536, 510 - mx - mn);
      if (mx == r) num = (g >= b) ? g - b : 6 * d - (b - g);
      else if (mx == g) num = 2 * d + b - r;
      else num = 4 * d + r - g;
      hue = round_div(num * 15360, d) % 92160;
    end
    if (sat != 0) begin
      if (lum < 32768) q = round_div(lum * (65536 + sat), 65536);
      else q = lum + sat - round_div(lum * sat, 65536);
      if (q > 65536) q = 65536;
      p = (2 * lum >= q) ? 2 * lum - q : 0;
    end
    count = (scheme == SchemeSingle) ? 1 : (scheme == SchemeComplement) ? 2 : 3;
    for (int k = 0; k < count; k++) begin
      if (sat == 0) begin
        c.red   = 8'(round_div(((lum > 65536) ? 65536 : lum) * 255, 65536));
        c.green = c.red;
        c.blue  = c.red;
      end else begin
        h = (hue + rot_offset(scheme, k)) % 92160;
        c.red   = shade_byte(p, q, (h + 30720) % 92160);
        c.green = shade_byte(p, q, h);
        c.blue  = shade_byte(p, q, (h + 92160 - 30720) % 92160);
      end
      c.index = 2'(k);
      c.last  = (k == count - 1);
      palette_q.push_back(c);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("%0t checker: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending_count = palette_q.size();

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    color_t want;
    if (!rst_ni) begin
      scheme = SchemeSingle;
      palette_q.delete();
    end else begin
      // Outputs first: a request accepted now cannot produce a color this edge.
      if (out_valid_o && !out_stall_i) begin
        if (palette_q.size() == 0) begin
          report_mismatch("color with nothing expected");
        end else begin
          want = palette_q.pop_front();
          if (out_red_o !== want.red) report_mismatch("red mismatch");
          if (out_green_o !== want.green) report_mismatch("green mismatch");
          if (out_blue_o !== want.blue) report_mismatch("blue mismatch");
          if (color_index_o !== want.index) report_mismatch("index mismatch");
          if (last_color_o !== want.last) report_mismatch("last flag mismatch");
        end
      end
      if (in_valid_i && !in_stall_o) predict_palette(base_red_i, base_green_i, base_blue_i);
      if (cfg_we_i) scheme = scheme_e'(cfg_wdata_i);
    end
  end

endmodule

>>> dv/tb_hsl_hue_rotation_palette.sv
// ---------------------------------------------------------------------------
// HSL hue rotation palette testbench
// Drives base colors through every scheme with random idling on both sides;
// the checker predicts each palette and compares it color by color.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hsl_hue_rotation_palette import hhr_pkg::*;;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] base_red_i = '0;
  logic [7:0] base_green_i = '0;
  logic [7:0] base_blue_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o;
  logic [1:0] color_index_o;
  logic       last_color_o;
  int         fail_count, pending_count;

  // Idle controls: quiet turns off random stalls and sender gaps, hold_cycles
  // forces a long receiver stall.
  bit quiet = 1'b0;
  int hold_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hsl_hue_rotation_palette u_top (.*);

  hhr_palette_checker u_chk (.*);

  // Receiver: random stall bursts, or a long hold when asked.
  initial begin
    int run;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        // Stall a burst; the next pass of the loop releases it.
        run = $urandom_range(1, 15);
        out_stall_i <= 1'b1;
        repeat (run - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until accepted; sender gaps come before it.
  task automatic send_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_red_i   <= r;
    base_green_i <= g;
    base_blue_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drain everything, let the pipeline empty, then write the scheme.
  task automatic set_scheme(scheme_e m);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_color();
    logic [7:0] r, g, b;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    // Now and then force ties and greys to hit the max-channel order.
    case ($urandom_range(0, 7))
      0: begin g = r; b = r; end
      1: g = r;
      2: b = g;
      3: b = r;
      default: ;
    endcase
    send_color(r, g, b);
  endtask

  initial begin
    scheme_e modes[4];
    modes = '{SchemeSingle, SchemeComplement, SchemeTriadic, SchemeAnalogous};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, greys, primaries, ties and red max with blue > green.
    foreach (modes[m]) begin
      set_scheme(modes[m]);
      send_color(8'h00, 8'h00, 8'h00);
      send_color(8'hff, 8'hff, 8'hff);
      send_color(8'h80, 8'h80, 8'h80);
      send_color(8'hff, 8'h00, 8'h00);
      send_color(8'h00, 8'hff, 8'h00);
      send_color(8'h00, 8'h00, 8'hff);
    end
    send_color(8'hff, 8'hff, 8'h00);
    send_color(8'h00, 8'hff, 8'hff);
    send_color(8'hc8, 8'h10, 8'h40);
    send_color(8'h01, 8'hfe, 8'h7f);

    // Long receiver hold while the sender keeps offering: fill and stall input.
    hold_cycles = 60;
    repeat (12) send_color(8'($urandom), 8'($urandom), 8'($urandom));

    // Random phases across all schemes, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      set_scheme(modes[ph % 4]);
      repeat (20) random_color();
    end
    // Final part with no idling on either side.
    quiet = 1'b1;
    set_scheme(SchemeAnalogous);
    repeat (20) random_color();
    set_scheme(SchemeSingle);
    repeat (10) random_color();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_hsl_hue_rotation_palette: done, clean");
    end else begin
      $display("tb_hsl_hue_rotation_palette: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("tb_hsl_hue_rotation_palette: done, errors");
    $finish;
  end

endmodule
